### rtl/c3zp_pkg.sv
// Package: shared types and constants for the 3x3 zero-padded image filter.
package c3zp_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 1024;
    localparam int PIXEL_BITS   = 8;
    localparam int COEF_BITS    = 16;
    localparam int KERNEL_DIM   = 3;
    localparam int CFG_BITS     = 48;
    localparam int CFG_IDX_BITS = 3;
    localparam int SIZE_BITS    = 11;
    localparam int ADDR_BITS    = $clog2(MAX_WIDTH);
    localparam int PROD_BITS    = PIXEL_BITS + 1 + COEF_BITS;
    localparam int COL_SUM_BITS = PROD_BITS + 2;
    localparam int RESULT_BITS  = 28;
    localparam int FIFO_DEPTH   = 8;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_COEF_TOP = 3'd0,
        CFG_COEF_MID = 3'd1,
        CFG_COEF_BOT = 3'd2,
        CFG_WIDTH    = 3'd3,
        CFG_HEIGHT   = 3'd4
    } t_cfg_index;

    typedef logic [PIXEL_BITS-1:0]        t_pixel;
    typedef logic signed [COEF_BITS-1:0]  t_coef;
    // index 0 is the top kernel row
    typedef t_pixel [KERNEL_DIM-1:0]      t_column;
    typedef t_coef  [KERNEL_DIM-1:0]      t_coef_col;

    // per-cell control: window shift and per-row tap enables
    typedef struct packed {
        logic                  shift;
        logic [KERNEL_DIM-1:0] row_en;
    } t_cell_ctrl;

    // line store write request from the window stage
    typedef struct packed {
        logic                 en;
        logic [ADDR_BITS-1:0] addr;
        t_pixel               pix;
    } t_line_wr;

    typedef struct packed {
        logic signed [RESULT_BITS-1:0] filtered;
        logic                          frame_last;
    } t_result;

endpackage

### rtl/c3zp_cell.sv
// Window cell: holds one kernel column of pixels and forms its masked column sum.
module c3zp_cell (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  c3zp_pkg::t_cell_ctrl                    i_ctrl,
    input  c3zp_pkg::t_column                       i_col,
    input  c3zp_pkg::t_coef_col                     i_coef,
    output c3zp_pkg::t_column                       o_col,
    output logic signed [c3zp_pkg::COL_SUM_BITS-1:0] o_sum
);

    c3zp_pkg::t_column                          r_col;
    logic signed [c3zp_pkg::PROD_BITS-1:0]      raw_prod [c3zp_pkg::KERNEL_DIM];
    logic signed [c3zp_pkg::PROD_BITS-1:0]      n_prod   [c3zp_pkg::KERNEL_DIM];
    logic signed [c3zp_pkg::PROD_BITS-1:0]      r_prod   [c3zp_pkg::KERNEL_DIM];
    logic signed [c3zp_pkg::COL_SUM_BITS-1:0]   n_sum;
    logic signed [c3zp_pkg::COL_SUM_BITS-1:0]   r_sum;

    // window column state, shifted in from the neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_ctrl.shift) begin
            r_col <= i_col;
        end
    end

    // tap products on the incoming column; masked taps give zero
    always_comb begin
        for (int k = 0; k < c3zp_pkg::KERNEL_DIM; k++) begin
            raw_prod[k] = $signed({1'b0, i_col[k]}) * $signed(i_coef[k]);
            n_prod[k]   = i_ctrl.row_en[k] ? raw_prod[k] : '0;
        end
    end

    // column sum of the registered products
    always_comb begin
        n_sum = c3zp_pkg::COL_SUM_BITS'(r_prod[0])
              + c3zp_pkg::COL_SUM_BITS'(r_prod[1])
              + c3zp_pkg::COL_SUM_BITS'(r_prod[2]);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < c3zp_pkg::KERNEL_DIM; k++) begin
            r_prod[k] <= n_prod[k];
        end
        r_sum <= n_sum;
    end

    assign o_col = r_col;
    assign o_sum = r_sum;

endmodule

### rtl/c3zp_line_store.sv
// Line stores: two row buffers with registered read, write-to-read bypass and a
// clearing sweep after reset.
module c3zp_line_store (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_rd_en,
    input  logic [c3zp_pkg::ADDR_BITS-1:0] i_rd_addr,
    input  c3zp_pkg::t_line_wr             i_wr,
    output c3zp_pkg::t_pixel               o_upper,
    output c3zp_pkg::t_pixel               o_lower,
    output logic                           o_busy
);

    c3zp_pkg::t_pixel r_upper_mem [c3zp_pkg::MAX_WIDTH];
    c3zp_pkg::t_pixel r_lower_mem [c3zp_pkg::MAX_WIDTH];

    c3zp_pkg::t_pixel                 r_rd_upper;
    c3zp_pkg::t_pixel                 r_rd_lower;
    logic                             r_fwd;
    c3zp_pkg::t_pixel                 r_fwd_upper;
    c3zp_pkg::t_pixel                 r_fwd_lower;
    logic                             r_busy;
    logic [c3zp_pkg::ADDR_BITS-1:0]   r_clr_addr;

    logic                             wr_en;
    logic [c3zp_pkg::ADDR_BITS-1:0]   wr_addr;
    c3zp_pkg::t_pixel                 wr_upper;
    c3zp_pkg::t_pixel                 wr_lower;

    // outside the clearing sweep, the upper row takes the old lower row and the lower row takes the new pixel
    always_comb begin
        if (r_busy) begin
            wr_en    = 1'b1;
            wr_addr  = r_clr_addr;
            wr_upper = '0;
            wr_lower = '0;
        end else begin
            wr_en    = i_wr.en;
            wr_addr  = i_wr.addr;
            wr_upper = o_lower;
            wr_lower = i_wr.pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_upper_mem[wr_addr] <= wr_upper;
        end
        if (i_rd_en) begin
            r_rd_upper <= r_upper_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_lower_mem[wr_addr] <= wr_lower;
        end
        if (i_rd_en) begin
            r_rd_lower <= r_lower_mem[i_rd_addr];
        end
    end

    // bypass: read and write of the same entry in one cycle returns the new data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr.en && (i_wr.addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_upper <= wr_upper;
            r_fwd_lower <= wr_lower;
        end
    end

    // clearing sweep, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == '1) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_upper = r_fwd ? r_fwd_upper : r_rd_upper;
    assign o_lower = r_fwd ? r_fwd_lower : r_rd_lower;
    assign o_busy  = r_busy;

endmodule

### rtl/c3zp_out_fifo.sv
// Result queue between the filter pipeline and the output channel.
module c3zp_out_fifo (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  c3zp_pkg::t_result                  i_data,
    output logic                               o_valid,
    input  logic                               i_ready,
    output c3zp_pkg::t_result                  o_data,
    output logic [c3zp_pkg::FIFO_CNT_BITS-1:0] o_count
);

    c3zp_pkg::t_result                    r_mem [c3zp_pkg::FIFO_DEPTH];
    logic [c3zp_pkg::FIFO_PTR_BITS-1:0]   r_wr_ptr;
    logic [c3zp_pkg::FIFO_PTR_BITS-1:0]   r_rd_ptr;
    logic [c3zp_pkg::FIFO_CNT_BITS-1:0]   r_count;
    logic [c3zp_pkg::FIFO_CNT_BITS-1:0]   n_count;
    logic                                 pop;

    assign pop = o_valid && i_ready;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

### rtl/conv3x3_zero_pad_image_unit.sv
// Top level: streaming 3x3 convolution with zero padding over a chain of window cells.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+-----------------------------------
//  pixel in | i_valid / o_ready          | i_pixel[7:0], i_drain
//  result   | o_valid / i_ready          | o_filtered[27:0] (signed), o_frame_last
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index[2:0], i_cfg_data[47:0]
//
// One item per clock while o_ready is high. A result reaches the output queue from the
// item that causes it through the line store read, tap products and column sums.
// After reset the line stores are swept clear, all 1024 entries, with o_ready low;
// configuration writes are taken throughout.
// The output queue holds 8 results; o_ready drops while queued plus in-flight
// results reach 8, so a stalled output never loses data.
module conv3x3_zero_pad_image_unit (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [c3zp_pkg::PIXEL_BITS-1:0]         i_pixel,
    input  logic                                    i_drain,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [c3zp_pkg::RESULT_BITS-1:0] o_filtered,
    output logic                                    o_frame_last,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [c3zp_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [c3zp_pkg::CFG_BITS-1:0]           i_cfg_data
);

    localparam int SB = c3zp_pkg::SIZE_BITS;
    localparam int KD = c3zp_pkg::KERNEL_DIM;
    localparam int CB = c3zp_pkg::COEF_BITS;

    // configuration registers
    logic [c3zp_pkg::CFG_BITS-1:0] r_coef_top;
    logic [c3zp_pkg::CFG_BITS-1:0] r_coef_mid;
    logic [c3zp_pkg::CFG_BITS-1:0] r_coef_bot;
    logic [SB-1:0]                 r_width;
    logic [SB-1:0]                 r_height;

    // position counters
    logic [SB-1:0] r_in_col;
    logic [SB-1:0] r_in_row;
    logic [SB-1:0] r_out_col;
    logic [SB-1:0] r_out_row;
    logic [SB-1:0] n_in_col;
    logic [SB-1:0] n_in_row;
    logic [SB-1:0] n_out_col;
    logic [SB-1:0] n_out_row;

    // window stage registers
    logic                           r_s1_valid;
    logic                           r_s1_emit;
    logic                           r_s1_last;
    c3zp_pkg::t_pixel               r_s1_pix;
    logic [c3zp_pkg::ADDR_BITS-1:0] r_s1_addr;
    logic [KD-1:0]                  r_s1_row_en;
    logic                           r_s1_left;
    logic                           r_s1_right;

    // product and column-sum stage flags
    logic r_s2_valid;
    logic r_s2_last;
    logic r_s3_valid;
    logic r_s3_last;

    // input stage decode
    logic                  accept;
    logic [SB-1:0]         w_eff;
    logic [SB-1:0]         h_eff;
    logic                  wrap_in;
    logic                  wrap_out;
    logic [SB-1:0]         cur_col;
    logic [SB-1:0]         cur_row;
    logic [SB-1:0]         oc;
    logic [SB-1:0]         orow;
    logic [SB:0]           oc_p1;
    logic [SB:0]           orow_p1;
    logic                  emit;
    logic                  last;
    c3zp_pkg::t_pixel      pix;
    logic                  top_en;
    logic                  bot_en;
    logic                  left_en;
    logic                  right_en;

    // line store and cells
    logic                           ls_busy;
    c3zp_pkg::t_pixel               ls_upper;
    c3zp_pkg::t_pixel               ls_lower;
    c3zp_pkg::t_line_wr             ls_wr;
    c3zp_pkg::t_column              new_col;
    c3zp_pkg::t_column              col_in   [KD];
    c3zp_pkg::t_column              col_out  [KD];
    c3zp_pkg::t_coef_col            coef_col [KD];
    c3zp_pkg::t_cell_ctrl           cell_ctrl [KD];
    logic signed [c3zp_pkg::COL_SUM_BITS-1:0] col_sum [KD];

    // output queue
    c3zp_pkg::t_result                    res_in;
    c3zp_pkg::t_result                    res_out;
    logic [c3zp_pkg::FIFO_CNT_BITS-1:0]   fifo_count;
    logic [c3zp_pkg::FIFO_CNT_BITS-1:0]   pending;

    // configuration writes, always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_top <= '0;
            r_coef_mid <= '0;
            r_coef_bot <= '0;
            r_width    <= SB'(c3zp_pkg::MAX_WIDTH);
            r_height   <= SB'(c3zp_pkg::MAX_HEIGHT);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                c3zp_pkg::CFG_COEF_TOP: r_coef_top <= i_cfg_data;
                c3zp_pkg::CFG_COEF_MID: r_coef_mid <= i_cfg_data;
                c3zp_pkg::CFG_COEF_BOT: r_coef_bot <= i_cfg_data;
                c3zp_pkg::CFG_WIDTH:    r_width    <= i_cfg_data[SB-1:0];
                c3zp_pkg::CFG_HEIGHT:   r_height   <= i_cfg_data[SB-1:0];
                default: ;
            endcase
        end
    end

    // effective frame size: zero acts as one, large values clamp to the maximum
    always_comb begin
        if (r_width == '0) begin
            w_eff = SB'(1);
        end else if (r_width > SB'(c3zp_pkg::MAX_WIDTH)) begin
            w_eff = SB'(c3zp_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = SB'(1);
        end else if (r_height > SB'(c3zp_pkg::MAX_HEIGHT)) begin
            h_eff = SB'(c3zp_pkg::MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
    end

    // accept when the line stores are not clearing and the queue has room for every result still in flight
    assign pending = fifo_count
                   + c3zp_pkg::FIFO_CNT_BITS'(r_s1_valid && r_s1_emit)
                   + c3zp_pkg::FIFO_CNT_BITS'(r_s2_valid)
                   + c3zp_pkg::FIFO_CNT_BITS'(r_s3_valid);
    assign o_ready = !ls_busy && (pending < c3zp_pkg::FIFO_CNT_BITS'(c3zp_pkg::FIFO_DEPTH));
    assign accept  = i_valid && o_ready;

    // input stage: wrap counters, decode borders, pick the pixel
    always_comb begin
        wrap_in  = (r_in_col >= w_eff);
        cur_col  = wrap_in ? '0 : r_in_col;
        cur_row  = (wrap_in && (r_in_row != '1)) ? r_in_row + 1'b1 : r_in_row;
        wrap_out = (r_out_col >= w_eff);
        oc       = wrap_out ? '0 : r_out_col;
        orow     = wrap_out ? r_out_row + 1'b1 : r_out_row;
        oc_p1    = {1'b0, oc} + 1'b1;
        orow_p1  = {1'b0, orow} + 1'b1;

        emit = (cur_row >= SB'(2)) || ((cur_row == SB'(1)) && (cur_col != '0));
        last = (orow_p1 >= {1'b0, h_eff}) && (oc_p1 >= {1'b0, w_eff});

        pix = (i_drain || (cur_row >= h_eff)) ? '0 : i_pixel;

        top_en   = (orow != '0);
        bot_en   = (orow_p1 < {1'b0, h_eff});
        left_en  = (oc != '0);
        // at column 0 the right column of the pending window is padding
        right_en = (oc_p1 < {1'b0, w_eff}) && (cur_col != '0);

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (accept) begin
            if (emit && last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else begin
                n_in_col  = cur_col + 1'b1;
                n_in_row  = cur_row;
                n_out_col = oc;
                n_out_row = orow;
                if (emit) begin
                    if (oc_p1 >= {1'b0, w_eff}) begin
                        n_out_col = '0;
                        n_out_row = orow + 1'b1;
                    end else begin
                        n_out_col = oc_p1[SB-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // window stage and result flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_emit  <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_s1_emit  <= accept && emit;
            r_s2_valid <= r_s1_valid && r_s1_emit;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_last   <= last;
            r_s1_pix    <= pix;
            r_s1_addr   <= cur_col[c3zp_pkg::ADDR_BITS-1:0];
            r_s1_row_en <= {bot_en, 1'b1, top_en};
            r_s1_left   <= left_en;
            r_s1_right  <= right_en;
        end
        r_s2_last <= r_s1_last;
        r_s3_last <= r_s2_last;
    end

    // line stores, read at the input transfer, written in the window stage
    assign ls_wr.en   = r_s1_valid;
    assign ls_wr.addr = r_s1_addr;
    assign ls_wr.pix  = r_s1_pix;

    c3zp_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (cur_col[c3zp_pkg::ADDR_BITS-1:0]),
        .i_wr      (ls_wr),
        .o_upper   (ls_upper),
        .o_lower   (ls_lower),
        .o_busy    (ls_busy)
    );

    assign new_col = {r_s1_pix, ls_lower, ls_upper};

    // cell chain: columns move from the right cell toward the left cell
    assign col_in[0] = col_out[1];
    assign col_in[1] = col_out[2];
    assign col_in[2] = new_col;

    always_comb begin
        cell_ctrl[0].shift  = r_s1_valid;
        cell_ctrl[0].row_en = r_s1_row_en & {KD{r_s1_left}};
        cell_ctrl[1].shift  = r_s1_valid;
        cell_ctrl[1].row_en = r_s1_row_en;
        cell_ctrl[2].shift  = r_s1_valid;
        cell_ctrl[2].row_en = r_s1_row_en & {KD{r_s1_right}};
    end

    for (genvar k = 0; k < KD; k++) begin : g_cell
        assign coef_col[k] = {c3zp_pkg::t_coef'(r_coef_bot[k*CB +: CB]),
                              c3zp_pkg::t_coef'(r_coef_mid[k*CB +: CB]),
                              c3zp_pkg::t_coef'(r_coef_top[k*CB +: CB])};

        c3zp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (cell_ctrl[k]),
            .i_col   (col_in[k]),
            .i_coef  (coef_col[k]),
            .o_col   (col_out[k]),
            .o_sum   (col_sum[k])
        );
    end

    // final sum of the three column sums
    always_comb begin
        res_in.filtered   = c3zp_pkg::RESULT_BITS'(col_sum[0])
                          + c3zp_pkg::RESULT_BITS'(col_sum[1])
                          + c3zp_pkg::RESULT_BITS'(col_sum[2]);
        res_in.frame_last = r_s3_last;
    end

    c3zp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s3_valid),
        .i_data  (res_in),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (res_out),
        .o_count (fifo_count)
    );

    assign o_filtered   = res_out.filtered;
    assign o_frame_last = res_out.frame_last;

endmodule
